// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the run-length histogram RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define RRLH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication violated");

// Next-cycle implication.
`define RRLH_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

// Condition that must never be seen.
`define RRLH_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`endif

// ===== hdl/rrlh_pkg.sv =====
// Shared types, constants and helpers of the run-length histogram.
`timescale 1ns / 1ps
package rrlh_pkg;

	localparam int ADDRESS_BITS_DEF      = 48;
	localparam int BUCKET_COUNT_DEF      = 64;
	localparam int GRANULARITY_COUNT_DEF = 5;

	localparam int REG_COUNT = 5;
	localparam int SHIFT_W   = 6;
	localparam int CFG_IDX_W = 3;
	localparam int OPC_W     = 2;
	localparam int GSEL_W    = 3;
	localparam int BSEL_W    = 6;
	localparam int VALUE_W   = 32;
	localparam int USED_W    = 7;

	// shift value that folds every address into one region
	localparam logic [SHIFT_W-1:0] SHIFT_ALL = 6'd63;

	localparam logic [SHIFT_W-1:0] SHIFT_RESET [REG_COUNT] = '{
		6'd6, 6'd8, 6'd10, 6'd11, 6'd13
	};

	// result buffer
	localparam int OUT_DEPTH = 3;
	localparam int OUT_PTR_W = 2;
	localparam int OUT_CNT_W = 2;

	typedef enum logic [OPC_W-1:0] {
		OP_SAMPLE = 2'd0,
		OP_FLUSH  = 2'd1,
		OP_READ   = 2'd2,
		OP_CLEAR  = 2'd3
	} opcode_t;

	typedef enum logic {
		CLR_SWEEP = 1'b0,
		CLR_RUN   = 1'b1
	} clr_state_t;

	typedef struct packed {
		logic    fire;
		opcode_t op;
		logic    pass_open;
		logic    read_sel;
		logic    sweep_we;
	} lane_ctl_t;

	typedef struct packed {
		logic [VALUE_W-1:0] bucket_value;
		logic [USED_W-1:0]  used_buckets;
	} result_t;

	function automatic logic [VALUE_W-1:0] sat_inc(input logic [VALUE_W-1:0] v);
		return (v == '1) ? v : v + VALUE_W'(1);
	endfunction

endpackage

// ===== hdl/rrlh_item_if.sv =====
// Input item channel.
`timescale 1ns / 1ps
interface rrlh_item_if #(
	parameter int ADDRESS_BITS = rrlh_pkg::ADDRESS_BITS_DEF
);
	import rrlh_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [OPC_W-1:0]        opcode;
	logic [ADDRESS_BITS-1:0] sample_address;
	logic [GSEL_W-1:0]       granularity_select;
	logic [BSEL_W-1:0]       bucket_select;

	modport source (output valid, opcode, sample_address, granularity_select, bucket_select,
		input ready);
	modport sink (input valid, opcode, sample_address, granularity_select, bucket_select,
		output ready);
endinterface

// ===== hdl/rrlh_result_if.sv =====
// Result channel.
`timescale 1ns / 1ps
interface rrlh_result_if;
	import rrlh_pkg::*;

	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] bucket_value;
	logic [USED_W-1:0]  used_buckets;

	modport source (output valid, bucket_value, used_buckets, input ready);
	modport sink (input valid, bucket_value, used_buckets, output ready);
endinterface

// ===== hdl/rrlh_cfg_if.sv =====
// Configuration write channel.
`timescale 1ns / 1ps
interface rrlh_cfg_if;
	import rrlh_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [SHIFT_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/rrlh_ram.sv =====
// Generic single-write, single-read RAM with registered read (read-first).
`timescale 1ns / 1ps
module rrlh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hdl/rrlh_lane.sv =====
// One granularity: run tracking, bucket RAM read-modify-write and used count.
`timescale 1ns / 1ps
module rrlh_lane #(
	parameter int ADDRESS_BITS = rrlh_pkg::ADDRESS_BITS_DEF,
	parameter int BUCKET_COUNT = rrlh_pkg::BUCKET_COUNT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [rrlh_pkg::SHIFT_W-1:0]    shift,
	input  rrlh_pkg::lane_ctl_t             ctl,
	input  logic [ADDRESS_BITS-1:0]         address,
	input  logic [$clog2(BUCKET_COUNT)-1:0] bsel_addr,
	input  logic [$clog2(BUCKET_COUNT)-1:0] sweep_addr,
	output logic [rrlh_pkg::VALUE_W-1:0]    data_s1,
	output logic [$clog2(BUCKET_COUNT):0]   used
);
	import rrlh_pkg::*;

	localparam int IDX_W = $clog2(BUCKET_COUNT);
	localparam logic [ADDRESS_BITS-1:0] ADDR_ONES = '1;
	localparam logic [VALUE_W-1:0] LAST_LEN = VALUE_W'(BUCKET_COUNT - 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUCKET_COUNT - 1);

	logic [ADDRESS_BITS-1:0] run_region_q;
	logic [VALUE_W-1:0]      run_len_q;
	logic [IDX_W:0]          used_q;

	logic [ADDRESS_BITS-1:0] region_now;
	logic                    add;
	logic [VALUE_W-1:0]      len_next;
	logic [IDX_W-1:0]        idx;
	logic [IDX_W:0]          idx_p1;
	logic [IDX_W-1:0]        raddr;

	logic             add_s1;
	logic [IDX_W-1:0] raddr_s1;

	logic               wr_v_q;
	logic [IDX_W-1:0]   wr_addr_q;
	logic [VALUE_W-1:0] wr_data_q;

	logic               we;
	logic [IDX_W-1:0]   waddr;
	logic [VALUE_W-1:0] wdata;
	logic [VALUE_W-1:0] ram_rdata;

	assign region_now = (shift == SHIFT_ALL) ? '0 : (address & (ADDR_ONES << shift));

	// finished run goes into bucket min(len, last)
	assign idx    = (run_len_q >= LAST_LEN) ? LAST_IDX : run_len_q[IDX_W-1:0];
	assign idx_p1 = {1'b0, idx} + (IDX_W + 1)'(1);

	always_comb begin
		add      = 1'b0;
		len_next = run_len_q;
		case (ctl.op)
			OP_SAMPLE: begin
				if (!ctl.pass_open) begin
					len_next = VALUE_W'(1);
				end else if (region_now == run_region_q) begin
					len_next = sat_inc(run_len_q);
				end else begin
					add      = 1'b1;
					len_next = VALUE_W'(1);
				end
			end
			OP_FLUSH: begin
				add      = (run_len_q != '0);
				len_next = '0;
			end
			default: begin
				add      = 1'b0;
				len_next = run_len_q;
			end
		endcase
	end

	assign raddr = ctl.read_sel ? bsel_addr : idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_region_q <= '0;
			run_len_q    <= '0;
			used_q       <= '0;
		end else if (ctl.fire) begin
			if (ctl.op == OP_SAMPLE) begin
				run_region_q <= region_now;
			end
			if (ctl.op == OP_SAMPLE || ctl.op == OP_FLUSH) begin
				run_len_q <= len_next;
			end
			if (ctl.op == OP_CLEAR) begin
				used_q <= '0;
			end else if (add && used_q < idx_p1) begin
				used_q <= idx_p1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			add_s1 <= 1'b0;
		end else begin
			add_s1 <= ctl.fire && add;
		end
	end

	always_ff @(posedge clk) begin
		raddr_s1 <= raddr;
	end

	// bypass the write that landed at the same edge as our read
	assign data_s1 = (wr_v_q && wr_addr_q == raddr_s1) ? wr_data_q : ram_rdata;

	assign we    = ctl.sweep_we || add_s1;
	assign waddr = ctl.sweep_we ? sweep_addr : raddr_s1;
	assign wdata = ctl.sweep_we ? '0 : sat_inc(data_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_v_q <= 1'b0;
		end else begin
			wr_v_q <= we;
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_q <= waddr;
		wr_data_q <= wdata;
	end

	rrlh_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(BUCKET_COUNT)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	assign used = used_q;

	`include "assert_macros.svh"

	`RRLH_ASSERT_NEVER(a_sweep_vs_update, clk, arst_n, ctl.sweep_we && add_s1)
	`RRLH_ASSERT_IMP(a_used_bound, clk, arst_n, 1'b1, used_q <= (IDX_W + 1)'(BUCKET_COUNT))
endmodule

// ===== hdl/rrlh_out_buf.sv =====
// Small result FIFO that decouples the pipeline from the result consumer.
`timescale 1ns / 1ps
module rrlh_out_buf (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  rrlh_pkg::result_t             push_data,
	output logic [rrlh_pkg::OUT_CNT_W-1:0] count,
	rrlh_result_if.source                 result
);
	import rrlh_pkg::*;

	result_t               entry_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0]  head_q;
	logic [OUT_PTR_W-1:0]  tail_q;
	logic [OUT_CNT_W-1:0]  cnt_q;
	logic                  pop;
	result_t               head_data;

	assign pop = result.valid && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				tail_q <= (tail_q == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : tail_q + OUT_PTR_W'(1);
			end
			if (pop) begin
				head_q <= (head_q == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : head_q + OUT_PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + OUT_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - OUT_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[tail_q] <= push_data;
		end
	end

	assign head_data           = entry_q[head_q];
	assign result.valid        = (cnt_q != '0);
	assign result.bucket_value = head_data.bucket_value;
	assign result.used_buckets = head_data.used_buckets;
	assign count               = cnt_q;

	`include "assert_macros.svh"

	`RRLH_ASSERT_NEVER(a_no_overflow, clk, arst_n,
		push && !pop && cnt_q == OUT_CNT_W'(OUT_DEPTH))
endmodule

// ===== hdl/region_run_length_histogram.sv =====
// Top level of the region run-length histogram.
//
//  channel | dir | transaction moves
//  --------+-----+--------------------------------------------------------------
//  item    | in  | opcode, sample_address, granularity_select, bucket_select
//  result  | out | bucket_value, used_buckets (one per item)
//  cfg     | in  | index, data: write of one region shift register
//
//  One item per cycle is taken while item.ready is high; each result passes
//  the update stage register and then the result buffer. The pace is set
//  by the per-granularity bucket RAM: the update read at acceptance,
//  increment and write-back in the cycle after, with a one-entry bypass for
//  back-to-back hits on the same bucket. After reset and after each clear
//  transaction, the bucket RAMs are swept to zero, one row (all granularities
//  in parallel) per cycle, with item.ready low until the sweep ends.
//  cfg writes are taken at any time. A three-entry result buffer lets items
//  keep flowing while result stalls; item.ready drops once buffered results
//  plus the one in the update stage reach three.
`timescale 1ns / 1ps
module region_run_length_histogram #(
	parameter int ADDRESS_BITS      = rrlh_pkg::ADDRESS_BITS_DEF,
	parameter int BUCKET_COUNT      = rrlh_pkg::BUCKET_COUNT_DEF,
	parameter int GRANULARITY_COUNT = rrlh_pkg::GRANULARITY_COUNT_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	rrlh_item_if.sink    item,
	rrlh_result_if.source result,
	rrlh_cfg_if.sink     cfg
);
	import rrlh_pkg::*;

	localparam int IDX_W = $clog2(BUCKET_COUNT);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUCKET_COUNT - 1);

	// region shift registers
	logic [SHIFT_W-1:0] shift_q [REG_COUNT];

	// clear sweep
	clr_state_t       state_q;
	clr_state_t       state_d;
	logic [IDX_W-1:0] sweep_q;
	logic             sweep_we;
	logic             run_ok;

	// accept stage
	opcode_t          op;
	logic             item_fire;
	logic             gsel_ok;
	logic             bsel_ok;
	logic [IDX_W-1:0] bsel_addr;
	logic [IDX_W:0]   sel_used;
	logic             pass_open_q;

	lane_ctl_t          lane_ctl  [GRANULARITY_COUNT];
	logic [VALUE_W-1:0] lane_data [GRANULARITY_COUNT];
	logic [IDX_W:0]     lane_used [GRANULARITY_COUNT];

	// update stage
	logic              v_s1;
	logic              rd_s1;
	logic [GSEL_W-1:0] gsel_s1;
	logic [USED_W-1:0] used_s1;
	logic [VALUE_W-1:0] value_s1;
	result_t           res_s1;

	// result buffer
	logic [OUT_CNT_W-1:0] buf_cnt;
	logic [OUT_CNT_W:0]   in_flight;

	// ---------------- configuration ----------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++) begin
				shift_q[i] <= SHIFT_RESET[i];
			end
		end else if (cfg.valid) begin
			// writes past the last register fall through unmatched
			for (int i = 0; i < REG_COUNT; i++) begin
				if (cfg.index == CFG_IDX_W'(i)) begin
					shift_q[i] <= cfg.data;
				end
			end
		end
	end

	// ---------------- clear sweep control ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			CLR_SWEEP: begin
				if (sweep_q == LAST_IDX) begin
					state_d = CLR_RUN;
				end
			end
			CLR_RUN: begin
				if (item_fire && op == OP_CLEAR) begin
					state_d = CLR_SWEEP;
				end
			end
			default: begin
				state_d = CLR_SWEEP;
			end
		endcase
	end

	always_comb begin
		case (state_q)
			CLR_SWEEP: begin
				sweep_we = 1'b1;
				run_ok   = 1'b0;
			end
			CLR_RUN: begin
				sweep_we = 1'b0;
				run_ok   = 1'b1;
			end
			default: begin
				sweep_we = 1'b0;
				run_ok   = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CLR_SWEEP;
			sweep_q <= '0;
		end else begin
			state_q <= state_d;
			if (sweep_we) begin
				sweep_q <= (sweep_q == LAST_IDX) ? '0 : sweep_q + IDX_W'(1);
			end
		end
	end

	// ---------------- accept stage ----------------
	// room check uses only registered counts: buffer entries plus the update stage
	assign in_flight  = {1'b0, buf_cnt} + (OUT_CNT_W + 1)'(v_s1);
	assign item.ready = run_ok && (in_flight < (OUT_CNT_W + 1)'(OUT_DEPTH));
	assign item_fire  = item.valid && item.ready;

	assign op        = opcode_t'(item.opcode);
	assign gsel_ok   = int'(item.granularity_select) < GRANULARITY_COUNT;
	assign bsel_ok   = int'(item.bucket_select) < BUCKET_COUNT;
	assign bsel_addr = IDX_W'(item.bucket_select);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_open_q <= 1'b0;
		end else if (item_fire) begin
			if (op == OP_SAMPLE) begin
				pass_open_q <= 1'b1;
			end else if (op == OP_FLUSH) begin
				pass_open_q <= 1'b0;
			end
		end
	end

	for (genvar g = 0; g < GRANULARITY_COUNT; g++) begin : g_lane
		// granularities past the last register share it
		localparam int SR = (g < REG_COUNT) ? g : REG_COUNT - 1;

		assign lane_ctl[g].fire      = item_fire;
		assign lane_ctl[g].op        = op;
		assign lane_ctl[g].pass_open = pass_open_q;
		assign lane_ctl[g].read_sel  = (op == OP_READ) && (int'(item.granularity_select) == g);
		assign lane_ctl[g].sweep_we  = sweep_we;

		rrlh_lane #(
			.ADDRESS_BITS(ADDRESS_BITS),
			.BUCKET_COUNT(BUCKET_COUNT)
		) u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.shift     (shift_q[SR]),
			.ctl       (lane_ctl[g]),
			.address   (item.sample_address),
			.bsel_addr (bsel_addr),
			.sweep_addr(sweep_q),
			.data_s1   (lane_data[g]),
			.used      (lane_used[g])
		);
	end

	// used count is final at acceptance: every earlier item has updated it
	always_comb begin
		sel_used = '0;
		for (int g = 0; g < GRANULARITY_COUNT; g++) begin
			if (int'(item.granularity_select) == g) begin
				sel_used = lane_used[g];
			end
		end
	end

	// ---------------- update stage ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= item_fire;
		end
	end

	always_ff @(posedge clk) begin
		rd_s1   <= (op == OP_READ) && gsel_ok && bsel_ok;
		gsel_s1 <= item.granularity_select;
		used_s1 <= ((op == OP_READ) && gsel_ok) ? USED_W'(sel_used) : '0;
	end

	always_comb begin
		value_s1 = '0;
		for (int g = 0; g < GRANULARITY_COUNT; g++) begin
			if (rd_s1 && int'(gsel_s1) == g) begin
				value_s1 = lane_data[g];
			end
		end
	end

	assign res_s1.bucket_value = value_s1;
	assign res_s1.used_buckets = used_s1;

	rrlh_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (v_s1),
		.push_data(res_s1),
		.count    (buf_cnt),
		.result   (result)
	);

	`include "assert_macros.svh"

	`RRLH_ASSERT_NXT(a_clear_starts_sweep, clk, arst_n, item_fire && op == OP_CLEAR,
		state_q == CLR_SWEEP && sweep_q == '0)
	`RRLH_ASSERT_NXT(a_item_reaches_s1, clk, arst_n, item_fire, v_s1)
	`RRLH_ASSERT_NEVER(a_in_flight_bound, clk, arst_n,
		in_flight > (OUT_CNT_W + 1)'(OUT_DEPTH))
endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the region run-length histogram: predictor, driver and monitor.
`timescale 1ns / 1ps
module testbench;
	import rrlh_pkg::*;

	localparam int ADDR_W       = ADDRESS_BITS_DEF;
	localparam int NBUCKETS     = BUCKET_COUNT_DEF;
	localparam int NGRAN        = GRANULARITY_COUNT_DEF;
	localparam int LAST_BUCKET  = NBUCKETS - 1;
	localparam int RANDOM_OPS   = 820;
	// ~900 transactions; the limit is several times the worst case of a long source
	// gap, a long sink stall and a full clear sweep for every transaction
	localparam int CYCLE_LIMIT  = 1_000_000;
	// results trail their transaction through the update stage and result buffer; give the pipe time to go quiet
	localparam int DRAIN_CYCLES = 32;
	localparam int MAX_REPORTS  = 200;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SHIFT_A = 3'd0,
		REG_SHIFT_B = 3'd1,
		REG_SHIFT_C = 3'd2,
		REG_SHIFT_D = 3'd3,
		REG_SHIFT_E = 3'd4
	} shift_reg_t;

	// how the five region shifts are picked for one phase
	typedef enum int {
		PLAN_RANDOM,	// anywhere in the documented 0..47
		PLAN_ZERO,		// byte-sized regions
		PLAN_TOP,		// largest documented region
		PLAN_FOLD,		// mostly beyond the address width, 63 folds everything into one region
		PLAN_WIDE		// full 6-bit field
	} shift_plan_t;

	typedef struct packed {
		opcode_t           op;
		logic [ADDR_W-1:0] addr;
		logic [GSEL_W-1:0] gsel;
		logic [BSEL_W-1:0] bsel;
	} hist_op_t;

	typedef struct packed {
		shift_reg_t         idx;
		logic [SHIFT_W-1:0] value;
	} shift_write_t;

	// ---------------------------------------------------------------
	// Clock, reset, channels and the block
	// ---------------------------------------------------------------
	logic clk = 1'b0;
	logic arst_n;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	rrlh_item_if #(.ADDRESS_BITS(ADDR_W)) item_ch ();
	rrlh_result_if result_ch ();
	rrlh_cfg_if cfg_ch ();

	region_run_length_histogram #(
		.ADDRESS_BITS(ADDR_W),
		.BUCKET_COUNT(NBUCKETS),
		.GRANULARITY_COUNT(NGRAN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch.sink),
		.result(result_ch.source),
		.cfg(cfg_ch.sink)
	);

	// ---------------------------------------------------------------
	// Shared bookkeeping
	// ---------------------------------------------------------------
	hist_op_t     pending_ops[$];      // transactions not yet put on the item channel
	shift_write_t pending_writes[$];   // shift register writes not yet issued
	result_t      readout_queue[$];    // expected results, oldest first

	int          items_outstanding = 0; // queued but not yet accepted
	int          cfg_outstanding   = 0;
	int          ops_queued        = 0;
	int unsigned mismatches        = 0;
	int unsigned cycle_count       = 0;

	// set at the rising edge, read by the drivers at the following falling edge
	bit item_fire = 1'b0;
	bit cfg_fire  = 1'b0;

	// idling controls, changed per phase
	bit item_gaps_on     = 1'b1;
	bit result_stalls_on = 1'b1;
	int item_gap         = 0;
	int result_stall     = 0;

	// ---------------------------------------------------------------
	// Predictor state: the histogram as it should be after every
	// accepted transaction
	// ---------------------------------------------------------------
	logic [SHIFT_W-1:0] shift_now   [REG_COUNT];
	logic [ADDR_W-1:0]  open_region [NGRAN];
	logic [VALUE_W-1:0] open_len    [NGRAN];
	logic               pass_open;
	logic [VALUE_W-1:0] hist        [NGRAN][NBUCKETS];
	logic [USED_W-1:0]  hist_used   [NGRAN];

	// Aligned region base of an address for one granularity. Shifts of 63
	// fold everything into region zero; 48..62 clear every address bit anyway.
	function automatic logic [ADDR_W-1:0] region_base(logic [ADDR_W-1:0] addr, int g);
		logic [SHIFT_W-1:0] s;
		logic [63:0]        keep;
		s = shift_now[g < REG_COUNT ? g : REG_COUNT - 1];
		if (s >= SHIFT_ALL)
			return '0;
		keep = ~((64'd1 << s) - 64'd1);
		return addr & keep[ADDR_W-1:0];
	endfunction

	// Count one finished run; long runs share the last bucket, counts saturate.
	function automatic void tally_run(int g, logic [VALUE_W-1:0] len);
		int b;
		b = (len < LAST_BUCKET) ? int'(len) : LAST_BUCKET;
		if (hist[g][b] != '1)
			hist[g][b] = hist[g][b] + 1'b1;
		if (hist_used[g] < b + 1)
			hist_used[g] = USED_W'(b + 1);
	endfunction

	// Advance the histogram by one transaction and return the result it owes.
	function automatic result_t apply_histogram_op(hist_op_t t);
		result_t           r;
		logic [ADDR_W-1:0] here;
		r = '0;
		case (t.op)
		OP_SAMPLE: begin
			// first sample of a pass anchors every granularity at its own region
			if (!pass_open) begin
				for (int g = 0; g < NGRAN; g++) begin
					open_region[g] = region_base(t.addr, g);
					open_len[g] = '0;
				end
				pass_open = 1'b1;
			end
			for (int g = 0; g < NGRAN; g++) begin
				here = region_base(t.addr, g);
				if (here == open_region[g]) begin
					if (open_len[g] != '1)
						open_len[g] = open_len[g] + 1'b1;
				end else begin
					tally_run(g, open_len[g]);
					open_len[g] = VALUE_W'(1);
					open_region[g] = here;
				end
			end
		end
		OP_FLUSH: begin
			// only nonzero runs count; a flush outside a pass changes nothing
			for (int g = 0; g < NGRAN; g++) begin
				if (open_len[g] != '0)
					tally_run(g, open_len[g]);
				open_len[g] = '0;
			end
			pass_open = 1'b0;
		end
		OP_READ: begin
			// out-of-range granularity reads back all zeros
			if (t.gsel < NGRAN) begin
				r.used_buckets = hist_used[t.gsel];
				r.bucket_value = hist[t.gsel][t.bsel];
			end
		end
		default: begin
			// clear drops the histograms but keeps the open runs
			for (int g = 0; g < NGRAN; g++) begin
				hist_used[g] = '0;
				for (int b = 0; b < NBUCKETS; b++)
					hist[g][b] = '0;
			end
		end
		endcase
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Reporting
	// ---------------------------------------------------------------
	task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("[%0t] mismatch, %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
	endtask

	// Short gaps mostly, the odd long one.
	function automatic int pick_gap(bit enabled);
		int roll;
		roll = $urandom_range(0, 99);
		if (!enabled || roll < 55)
			return 0;
		if (roll < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// ---------------------------------------------------------------
	// Item driver: inputs move on the falling edge only
	// ---------------------------------------------------------------
	always @(negedge clk) begin
		hist_op_t t;
		if (arst_n) begin
			if (!item_ch.valid || item_fire) begin
				if (item_gap > 0 || pending_ops.size() == 0) begin
					if (item_gap > 0)
						item_gap--;
					item_ch.valid <= 1'b0;
				end else begin
					t = pending_ops.pop_front();
					item_ch.opcode <= t.op;
					item_ch.sample_address <= t.addr;
					item_ch.granularity_select <= t.gsel;
					item_ch.bucket_select <= t.bsel;
					item_ch.valid <= 1'b1;
					item_gap = pick_gap(item_gaps_on);
				end
			end
		end
	end

	// Result sink: random back-pressure, independent of what is in flight
	always @(negedge clk) begin
		if (arst_n) begin
			if (result_stall > 0) begin
				result_stall--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
				result_stall = pick_gap(result_stalls_on);
			end
		end
	end

	// Configuration driver: back-to-back writes, issued only while idle
	always @(negedge clk) begin
		shift_write_t w;
		if (arst_n && (!cfg_ch.valid || cfg_fire)) begin
			if (pending_writes.size() > 0) begin
				w = pending_writes.pop_front();
				cfg_ch.index <= w.idx;
				cfg_ch.data <= w.value;
				cfg_ch.valid <= 1'b1;
			end else begin
				cfg_ch.valid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// Monitor: everything sampled on the rising edge. Accepted items
	// go through the predictor; accepted results are checked in order.
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		hist_op_t seen;
		result_t  want;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("status: fail");
			$finish;
		end else begin
			item_fire = arst_n && item_ch.valid && item_ch.ready;
			cfg_fire = arst_n && cfg_ch.valid && cfg_ch.ready;

			if (cfg_fire) begin
				if (cfg_ch.index < REG_COUNT)
					shift_now[cfg_ch.index] = cfg_ch.data;
				cfg_outstanding--;
			end

			if (item_fire) begin
				seen.op = opcode_t'(item_ch.opcode);
				seen.addr = item_ch.sample_address;
				seen.gsel = item_ch.granularity_select;
				seen.bsel = item_ch.bucket_select;
				readout_queue.push_back(apply_histogram_op(seen));
				items_outstanding--;
			end

			if (arst_n && result_ch.valid && result_ch.ready) begin
				if (readout_queue.size() == 0) begin
					report_mismatch("result with nothing outstanding", 64'd0,
						64'({result_ch.bucket_value, result_ch.used_buckets}));
				end else begin
					want = readout_queue.pop_front();
					if (result_ch.bucket_value !== want.bucket_value)
						report_mismatch("bucket_value", 64'(want.bucket_value),
							64'(result_ch.bucket_value));
					if (result_ch.used_buckets !== want.used_buckets)
						report_mismatch("used_buckets", 64'(want.used_buckets),
							64'(result_ch.used_buckets));
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------
	function automatic logic [ADDR_W-1:0] rand_addr();
		return ADDR_W'({$urandom(), $urandom()});
	endfunction

	// Fields a transaction does not use carry noise, so the block has to ignore them.
	task automatic push_op(opcode_t op, logic [ADDR_W-1:0] addr,
		logic [GSEL_W-1:0] g, logic [BSEL_W-1:0] b);
		hist_op_t t;
		t.op = op;
		t.addr = (op == OP_SAMPLE) ? addr : rand_addr();
		t.gsel = (op == OP_READ) ? g : GSEL_W'($urandom());
		t.bsel = (op == OP_READ) ? b : BSEL_W'($urandom());
		pending_ops.push_back(t);
		items_outstanding++;
		ops_queued++;
	endtask

	// Reads lean toward valid granularities and low buckets, where counts live.
	task automatic push_read();
		logic [GSEL_W-1:0] g;
		logic [BSEL_W-1:0] b;
		int                roll;
		g = ($urandom_range(0, 99) < 85) ? GSEL_W'($urandom_range(0, NGRAN - 1))
			: GSEL_W'($urandom_range(NGRAN, 7));
		roll = $urandom_range(0, 99);
		if (roll < 60)
			b = BSEL_W'($urandom_range(0, 7));
		else if (roll < 75)
			b = BSEL_W'(LAST_BUCKET);
		else
			b = BSEL_W'($urandom());
		push_op(OP_READ, '0, g, b);
	endtask

	// One sorted pass with random spacing. A few samples break the order,
	// and most passes end in a flush; the rest stay open into what follows.
	task automatic push_pass();
		logic [ADDR_W-1:0] addr;
		int                len;
		int                roll;
		roll = $urandom_range(0, 3);
		if (roll < 2)
			addr = rand_addr();
		else if (roll == 2)
			addr = ADDR_W'($urandom_range(0, 4095));
		else
			addr = {ADDR_W{1'b1}} - ADDR_W'($urandom_range(0, 1 << 20));
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(64, 130) : $urandom_range(1, 30);
		for (int i = 0; i < len; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 3) begin
				push_op(OP_SAMPLE, rand_addr(), '0, '0);
			end else begin
				push_op(OP_SAMPLE, addr, '0, '0);
				if (roll < 5)
					push_read();
			end
			roll = $urandom_range(0, 99);
			if (roll < 30)
				addr = addr;
			else if (roll < 70)
				addr = addr + ADDR_W'($urandom_range(1, 1 << $urandom_range(0, 8)));
			else if (roll < 95)
				addr = addr + ADDR_W'($urandom_range(1, 1 << $urandom_range(9, 20)));
			else
				addr = addr + (ADDR_W'($urandom()) << $urandom_range(8, 16));
		end
		if ($urandom_range(0, 99) < 85)
			push_op(OP_FLUSH, '0, '0, '0);
		repeat ($urandom_range(1, 3))
			push_read();
	endtask

	task automatic fill_phase(int budget);
		int start;
		int roll;
		start = ops_queued;
		while (ops_queued - start < budget) begin
			roll = $urandom_range(0, 99);
			if (roll < 70) begin
				push_pass();
			end else if (roll < 85) begin
				repeat ($urandom_range(1, 4))
					push_read();
			end else if (roll < 90) begin
				push_op(OP_CLEAR, '0, '0, '0);
			end else if (roll < 97) begin
				repeat ($urandom_range(1, 3))
					push_op(opcode_t'($urandom_range(0, 3)), rand_addr(),
						GSEL_W'($urandom()), BSEL_W'($urandom()));
			end else begin
				push_op(OP_FLUSH, '0, '0, '0);
			end
		end
	endtask

	task automatic load_shifts(shift_plan_t plan);
		shift_write_t w;
		for (int r = 0; r < REG_COUNT; r++) begin
			w.idx = shift_reg_t'(r);
			case (plan)
			PLAN_RANDOM: w.value = SHIFT_W'($urandom_range(0, 47));
			PLAN_ZERO:   w.value = '0;
			PLAN_TOP:    w.value = SHIFT_W'(47);
			PLAN_FOLD: begin
				if (w.idx == REG_SHIFT_A || w.idx == REG_SHIFT_E)
					w.value = SHIFT_ALL;
				else if (w.idx == REG_SHIFT_C)
					w.value = SHIFT_W'($urandom_range(0, 12));
				else
					w.value = SHIFT_W'($urandom_range(48, 62));
			end
			default:     w.value = SHIFT_W'($urandom());
			endcase
			pending_writes.push_back(w);
			cfg_outstanding++;
		end
		while (cfg_outstanding != 0)
			@(posedge clk);
	endtask

	// Quiet means every queued transaction accepted, every result back and every shift write taken.
	task automatic wait_idle();
		while (items_outstanding != 0 || readout_queue.size() != 0 || cfg_outstanding != 0)
			@(posedge clk);
	endtask

	// ---------------------------------------------------------------
	// Sequence of the run
	// ---------------------------------------------------------------
	initial begin
		int          phase;
		int          random_start;
		shift_plan_t plan;

		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.opcode = OP_SAMPLE;
		item_ch.sample_address = '0;
		item_ch.granularity_select = '0;
		item_ch.bucket_select = '0;
		result_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_SHIFT_A;
		cfg_ch.data = '0;

		// predictor starts from the reset state
		shift_now = SHIFT_RESET;
		pass_open = 1'b0;
		for (int g = 0; g < NGRAN; g++) begin
			open_region[g] = '0;
			open_len[g] = '0;
			hist_used[g] = '0;
			for (int b = 0; b < NBUCKETS; b++)
				hist[g][b] = '0;
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part, reset shifts (6, 8, 10, 11, 13)
		push_op(OP_READ, '0, 3'd0, 6'd0);                // empty histogram
		push_op(OP_FLUSH, '0, '0, '0);                   // flush with no pass open
		push_op(OP_SAMPLE, 48'h0, '0, '0);               // first sample opens the pass
		push_op(OP_SAMPLE, 48'h10, '0, '0);
		push_op(OP_SAMPLE, 48'h3F, '0, '0);              // last byte of the 64 B region
		push_op(OP_SAMPLE, 48'h40, '0, '0);              // finest granularity moves on
		push_op(OP_SAMPLE, 48'h2000, '0, '0);            // every granularity moves on
		push_op(OP_SAMPLE, {ADDR_W{1'b1}}, '0, '0);      // top of the address space
		push_op(OP_FLUSH, '0, '0, '0);
		push_op(OP_FLUSH, '0, '0, '0);                   // second flush is a no-op
		push_op(OP_READ, '0, 3'd0, 6'd3);
		push_op(OP_READ, '0, 3'd0, 6'd1);
		push_op(OP_READ, '0, 3'd4, 6'd4);
		push_op(OP_READ, '0, 3'd4, 6'd1);
		push_op(OP_READ, '0, 3'd5, 6'd1);                // granularity past the last
		push_op(OP_READ, '0, 3'd7, 6'd63);
		push_op(OP_READ, '0, 3'd2, 6'd63);               // long-run bucket
		push_op(OP_CLEAR, '0, '0, '0);
		push_op(OP_READ, '0, 3'd0, 6'd3);                // gone after the clear
		push_op(OP_SAMPLE, 48'h8000_0000_0000, '0, '0);
		push_op(OP_SAMPLE, 48'h8000_0000_0000, '0, '0);  // repeat address
		push_op(OP_FLUSH, '0, '0, '0);
		push_op(OP_READ, '0, 3'd3, 6'd2);
		wait_idle();

		// Random part: one shift setting per phase, idling varied per phase
		phase = 0;
		random_start = ops_queued;
		while (ops_queued - random_start < RANDOM_OPS) begin
			wait_idle();
			plan = shift_plan_t'(phase % 5);
			load_shifts(plan);
			item_gaps_on = (phase % 4) != 3;
			result_stalls_on = (phase % 4) < 2;
			fill_phase($urandom_range(80, 140));
			phase++;
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (readout_queue.size() != 0)
			report_mismatch("results never delivered", 64'd0, 64'(readout_queue.size()));

		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/rrlh_pkg.sv
hdl/rrlh_item_if.sv
hdl/rrlh_result_if.sv
hdl/rrlh_cfg_if.sv
hdl/rrlh_ram.sv
hdl/rrlh_lane.sv
hdl/rrlh_out_buf.sv
hdl/region_run_length_histogram.sv
test/testbench.sv
